/* rtl/core/mcli_pkg.sv */
// ----------------------------------------------------------------------------
// mcli_pkg
// Shared types and constants of the monotone curve interpolation core: the
// stored point format and the request and response bundles that pass between
// the sequencer, the fraction divider and the blend stage.
// ----------------------------------------------------------------------------
package mcli_pkg;

	// Width of a Q4.12 abscissa or ordinate.
	localparam int unsigned COORD_W = 16;
	// Width of the Q0.16 fraction, which can reach 1.0.
	localparam int unsigned FRAC_W = 17;
	// Width of a coordinate difference.
	localparam int unsigned DIFF_W = 17;
	// Width of the points_in_use register.
	localparam int unsigned COUNT_W = 7;
	// Width of the write index field.
	localparam int unsigned INDEX_W = 6;
	// Quotient bits produced by the serial divider, one per cycle.
	localparam int unsigned DIV_STEPS = 16;
	// Fraction value that stands for 1.0.
	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h1_0000;
	// Input function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// One stored curve point.
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} curve_point_t;

	// Request to the fraction divider: num and den are both positive, den > 0.
	typedef struct packed {
		logic               start;
		logic [COORD_W-1:0] num;
		logic [COORD_W-1:0] den;
	} div_req_t;

	// Divider result: floor(num * 65536 / den), saturated at 1.0.
	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] frac;
	} div_rsp_t;

	// Request to the blend stage.
	typedef struct packed {
		logic                     start;
		logic [FRAC_W-1:0]        frac;
		logic signed [DIFF_W-1:0] dy;
		logic signed [COORD_W-1:0] y0;
	} blend_req_t;

	// Blend stage result.
	typedef struct packed {
		logic                      done;
		logic signed [COORD_W-1:0] value;
	} blend_rsp_t;

endpackage

/* rtl/core/mcli_curve_mem.sv */
// ----------------------------------------------------------------------------
// mcli_curve_mem
// Point storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcli_curve_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  mcli_pkg::curve_point_t wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output mcli_pkg::curve_point_t rdata
);

	mcli_pkg::curve_point_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/mcli_frac_div.sv */
// ----------------------------------------------------------------------------
// mcli_frac_div
// Restoring divider that forms the Q0.16 segment fraction one bit per cycle.
// ----------------------------------------------------------------------------
module mcli_frac_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mcli_pkg::div_req_t req,
	output mcli_pkg::div_rsp_t rsp
);

	localparam int unsigned CW = $clog2(mcli_pkg::DIV_STEPS);

	logic                             busy_q;
	logic                             done_q;
	logic [CW-1:0]                    cnt_q;
	logic [mcli_pkg::COORD_W-1:0]     den_q;
	logic [mcli_pkg::COORD_W-1:0]     rem_q;
	logic [mcli_pkg::DIV_STEPS-1:0]   quo_q;
	logic [mcli_pkg::FRAC_W-1:0]      frac_q;
	logic [mcli_pkg::COORD_W:0]       rem_dbl;
	logic                             quo_bit;
	logic [mcli_pkg::COORD_W:0]       rem_sub;
	logic                             saturate;

	// A numerator at or above the denominator gives a fraction of 1.0 or
	// more, which clamps to 1.0 at once.
	assign saturate = (req.num >= req.den);

	// One restoring step: shift the remainder and try to subtract.
	always_comb begin
		rem_dbl = {rem_q, 1'b0};
		rem_sub = rem_dbl - {1'b0, den_q};
		quo_bit = (rem_dbl >= {1'b0, den_q});
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= !saturate;
				done_q <= saturate;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(mcli_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q  <= req.den;
			rem_q  <= req.num;
			quo_q  <= '0;
			frac_q <= mcli_pkg::FRAC_ONE;
		end else if (busy_q) begin
			rem_q  <= quo_bit ? rem_sub[mcli_pkg::COORD_W-1:0]
			                  : rem_dbl[mcli_pkg::COORD_W-1:0];
			quo_q  <= {quo_q[mcli_pkg::DIV_STEPS-2:0], quo_bit};
			frac_q <= {1'b0, quo_q[mcli_pkg::DIV_STEPS-2:0], quo_bit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.frac = frac_q;

endmodule

/* rtl/core/mcli_blend.sv */
// ----------------------------------------------------------------------------
// mcli_blend
// Two-stage blend: multiplies the fraction by the segment rise, scales it
// back by 2^16 with truncation toward zero and adds the lower ordinate.
// ----------------------------------------------------------------------------
module mcli_blend (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mcli_pkg::blend_req_t req,
	output mcli_pkg::blend_rsp_t rsp
);

	localparam int unsigned PW = mcli_pkg::FRAC_W + 1 + mcli_pkg::DIFF_W;

	logic                               valid_s1;
	logic                               valid_s2;
	logic signed [PW-1:0]               prod_s1;
	logic signed [mcli_pkg::COORD_W-1:0] y0_s1;
	logic signed [mcli_pkg::COORD_W-1:0] value_s2;
	logic signed [PW-1:0]               prod_adj;
	logic [mcli_pkg::COORD_W-1:0]       delta;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.start;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: signed product of the fraction and the rise.
	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_s1 <= $signed({1'b0, req.frac}) * req.dy;
			y0_s1   <= req.y0;
		end
	end

	// A negative product is biased so that the shift truncates toward zero.
	always_comb begin
		prod_adj = prod_s1 + (prod_s1[PW-1] ? PW'(16'hFFFF) : PW'(0));
		delta    = prod_adj[16 +: mcli_pkg::COORD_W];
	end

	// Stage 2: add the scaled rise to the lower ordinate.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			value_s2 <= y0_s1 + $signed(delta);
		end
	end

	assign rsp.done  = valid_s2;
	assign rsp.value = value_s2;

endmodule

/* rtl/core/monotone_curve_linear_interp_core.sv */
// ----------------------------------------------------------------------------
// monotone_curve_linear_interp_core
// Piecewise-linear lookup on a stored curve of Q4.12 points.
// ----------------------------------------------------------------------------
// The core takes one transaction at a time. A write transaction stores one
// point and leaves the core idle, ready for the next transaction. A query
// transaction runs a sequencer around the point memory, whose registered read
// port delivers one entry per cycle: it reads the first and last points, runs
// the lower-bound search (ceil(log2(n+1)) steps for n points in use, each a
// probe read and a compare), reads the segment ends, then lets the serial
// divider form the fraction and the blend pipeline form the value. Queries at
// or beyond an end point finish once that end point has been read. Results
// wait in an output register, so the next transaction can be accepted while
// a result is still pending.
// ----------------------------------------------------------------------------
module monotone_curve_linear_interp_core #(
	parameter int unsigned MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration: points_in_use.
	input  logic                                cfg_we,
	input  logic [mcli_pkg::COUNT_W-1:0]        cfg_wdata,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [mcli_pkg::INDEX_W-1:0]        point_index,
	input  logic signed [mcli_pkg::COORD_W-1:0] point_x,
	input  logic signed [mcli_pkg::COORD_W-1:0] point_y,
	input  logic signed [mcli_pkg::COORD_W-1:0] query_x,
	// Output channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [mcli_pkg::COORD_W-1:0] value,
	output logic                                at_edge
);

	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned NW = AW + 1;
	localparam int unsigned CW = mcli_pkg::COORD_W;
	localparam int unsigned DW = mcli_pkg::DIFF_W;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD0   = 4'd1;
	localparam logic [3:0] ST_RDN   = 4'd2;
	localparam logic [3:0] ST_CHKN  = 4'd3;
	localparam logic [3:0] ST_SRCH  = 4'd4;
	localparam logic [3:0] ST_CMP   = 4'd5;
	localparam logic [3:0] ST_RDA   = 4'd6;
	localparam logic [3:0] ST_RDB   = 4'd7;
	localparam logic [3:0] ST_SEG   = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_BLEND = 4'd10;
	localparam logic [3:0] ST_EMIT  = 4'd11;

	logic [3:0]                 state_q;
	logic [mcli_pkg::COUNT_W-1:0] points_in_use_q;
	logic [NW-1:0]              n_q;
	logic [NW-1:0]              lo_q;
	logic [NW-1:0]              count_q;
	logic [NW-1:0]              mid_q;
	logic signed [CW-1:0]       q_q;
	logic signed [CW-1:0]       first_y_q;
	logic signed [CW-1:0]       last_y_q;
	logic signed [CW-1:0]       x0_q;
	logic signed [CW-1:0]       y0_q;
	logic signed [CW-1:0]       res_value_q;
	logic                       res_edge_q;
	logic                       out_valid_q;
	logic signed [CW-1:0]       value_q;
	logic                       at_edge_q;

	logic                       in_fire;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	mcli_pkg::curve_point_t     mem_wdata;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	mcli_pkg::curve_point_t     rd;
	logic [31:0]                widx;
	logic [31:0]                n_full;
	logic [NW-1:0]              half;
	logic [NW-1:0]              mid;
	logic signed [DW-1:0]       den;
	logic signed [DW-1:0]       dx;
	logic signed [DW-1:0]       dy;
	logic                       emit_free;
	mcli_pkg::div_req_t         div_req;
	mcli_pkg::div_rsp_t         div_rsp;
	mcli_pkg::blend_req_t       blend_req;
	mcli_pkg::blend_rsp_t       blend_rsp;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign emit_free = !out_valid_q || out_ready;

	// Write transactions go straight into the point memory.
	assign widx      = 32'(point_index);
	assign mem_we    = in_fire && (func == mcli_pkg::FUNC_WRITE) && (widx < MAX_POINTS);
	assign mem_waddr = widx[AW-1:0];
	assign mem_wdata = '{x: point_x, y: point_y};

	// Points in use, clamped to the memory depth.
	assign n_full = (32'(points_in_use_q) > MAX_POINTS) ? 32'(MAX_POINTS)
	                                                   : 32'(points_in_use_q);

	// Search step: probe the middle of the remaining range.
	assign half = count_q >> 1;
	assign mid  = lo_q + half;

	// Segment arithmetic on the data just read.
	assign den = DW'(rd.x) - DW'(x0_q);
	assign dx  = DW'(q_q) - DW'(x0_q);
	assign dy  = DW'(rd.y) - DW'(y0_q);

	// Read address for each state.
	always_comb begin
		mem_re    = 1'b1;
		mem_raddr = '0;
		unique case (state_q)
			ST_RD0:  mem_raddr = '0;
			ST_RDN:  mem_raddr = AW'(n_q - 1'b1);
			ST_SRCH: mem_raddr = mid[AW-1:0];
			ST_RDA:  mem_raddr = AW'(lo_q - 1'b1);
			ST_RDB:  mem_raddr = lo_q[AW-1:0];
			default: mem_re    = 1'b0;
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_in_use_q <= '0;
		end else if (cfg_we) begin
			points_in_use_q <= cfg_wdata;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && func == mcli_pkg::FUNC_QUERY) begin
						state_q <= (n_full == 32'd0) ? ST_EMIT : ST_RD0;
					end
				end
				ST_RD0:  state_q <= ST_RDN;
				ST_RDN:  state_q <= (q_q <= rd.x) ? ST_EMIT : ST_CHKN;
				ST_CHKN: state_q <= (q_q >= rd.x) ? ST_EMIT : ST_SRCH;
				ST_SRCH: begin
					if (count_q != '0) begin
						state_q <= ST_CMP;
					end else if (lo_q == '0 || lo_q >= n_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_RDA;
					end
				end
				ST_CMP:  state_q <= ST_SRCH;
				ST_RDA:  state_q <= ST_RDB;
				ST_RDB:  state_q <= ST_SEG;
				ST_SEG:  state_q <= (den <= 0) ? ST_EMIT : ST_DIV;
				ST_DIV:  state_q <= div_rsp.done ? ST_BLEND : ST_DIV;
				ST_BLEND: state_q <= blend_rsp.done ? ST_EMIT : ST_BLEND;
				ST_EMIT: state_q <= emit_free ? ST_IDLE : ST_EMIT;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query datapath: search bounds, saved points and the pending result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				q_q         <= query_x;
				n_q         <= n_full[NW-1:0];
				res_value_q <= '0;
				res_edge_q  <= 1'b1;
			end
			ST_RDN: begin
				first_y_q   <= rd.y;
				res_value_q <= rd.y;
				res_edge_q  <= 1'b1;
			end
			ST_CHKN: begin
				last_y_q    <= rd.y;
				res_value_q <= rd.y;
				res_edge_q  <= 1'b1;
				lo_q        <= '0;
				count_q     <= n_q;
			end
			ST_SRCH: begin
				mid_q       <= mid;
				res_value_q <= (lo_q == '0) ? first_y_q : last_y_q;
				res_edge_q  <= 1'b1;
			end
			ST_CMP: begin
				if (rd.x < q_q) begin
					lo_q    <= mid_q + 1'b1;
					count_q <= count_q - (count_q >> 1) - 1'b1;
				end else begin
					count_q <= count_q >> 1;
				end
			end
			ST_SEG: begin
				res_value_q <= y0_q;
				res_edge_q  <= 1'b0;
			end
			ST_RDB: begin
				x0_q <= rd.x;
				y0_q <= rd.y;
			end
			ST_BLEND: begin
				if (blend_rsp.done) begin
					res_value_q <= blend_rsp.value;
				end
			end
			default: begin
			end
		endcase
	end

	// Divider and blend requests.
	always_comb begin
		div_req.start = (state_q == ST_SEG) && !(den <= 0);
		div_req.num   = dx[CW-1:0];
		div_req.den   = den[CW-1:0];
	end

	// The rise is captured with the divider start and held in the blend request.
	logic signed [DW-1:0] dy_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_SEG) begin
			dy_q <= dy;
		end
	end

	always_comb begin
		blend_req.start = (state_q == ST_DIV) && div_rsp.done;
		blend_req.frac  = div_rsp.frac;
		blend_req.dy    = dy_q;
		blend_req.y0    = y0_q;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && emit_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_free) begin
			value_q   <= res_value_q;
			at_edge_q <= res_edge_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign at_edge   = at_edge_q;

	mcli_curve_mem #(
		.DEPTH(MAX_POINTS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rd)
	);

	mcli_frac_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	mcli_blend u_blend (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (blend_req),
		.rsp   (blend_rsp)
	);

	// The divider only answers while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider result outside the divide state");

	// The search window never runs past the points in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (({1'b0, lo_q} + {1'b0, count_q}) <= {1'b0, n_q}))
		else $error("search window beyond points in use");

	// A new result is only loaded from the emit state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result shown without an emit");

	// A segment read only follows a search that stopped inside the curve.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDA) |-> (lo_q != '0 && lo_q < n_q))
		else $error("segment read at a curve end");

endmodule

/* verif/monotone_curve_linear_interp_checker.sv */
// ----------------------------------------------------------------------------
// monotone_curve_linear_interp_checker
// Watches both channels of the curve interpolation core, keeps its own copy
// of the point tables and the point count, predicts the result of every
// accepted lookup and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module monotone_curve_linear_interp_checker
	import mcli_pkg::*;
#(
	parameter int unsigned CURVE_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [COUNT_W-1:0]         cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       func,
	input  logic [INDEX_W-1:0]         point_index,
	input  logic signed [COORD_W-1:0]  point_x,
	input  logic signed [COORD_W-1:0]  point_y,
	input  logic signed [COORD_W-1:0]  query_x,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [COORD_W-1:0]  value,
	input  logic                       at_edge,
	output int                         error_count,
	output int                         pending_lookups,
	output int                         results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// One lookup result as the core reports it.
	typedef struct packed {
		logic signed [COORD_W-1:0] value;
		logic                      at_edge;
	} lookup_result_t;

	logic signed [COORD_W-1:0] abscissa_copy [CURVE_DEPTH];
	logic signed [COORD_W-1:0] ordinate_copy [CURVE_DEPTH];
	logic [COUNT_W-1:0]        active_points;
	lookup_result_t            expected_lookups [$];

	// Clamp at both ends, lower-bound search, then a truncated Q0.16 blend.
	function automatic lookup_result_t interpolate(input logic signed [COORD_W-1:0] qx);
		lookup_result_t r;
		int     n;
		int     lo;
		int     span;
		int     half;
		int     mid;
		int     x0;
		int     x1;
		int     y0;
		int     y1;
		int     den;
		longint frac;
		longint delta;
		longint sum;
		n = (active_points > CURVE_DEPTH) ? CURVE_DEPTH : int'(active_points);
		r.at_edge = 1'b1;
		if (n == 0) begin
			r.value = '0;
			return r;
		end
		if (qx <= abscissa_copy[0]) begin
			r.value = ordinate_copy[0];
			return r;
		end
		if (qx >= abscissa_copy[n-1]) begin
			r.value = ordinate_copy[n-1];
			return r;
		end
		lo = 0;
		span = n;
		while (span > 0) begin
			half = span / 2;
			mid = lo + half;
			if (abscissa_copy[mid] < qx) begin
				lo = mid + 1;
				span = span - half - 1;
			end else begin
				span = half;
			end
		end
		// The search ran off either end: treat it as a clamp.
		if (lo == 0) begin
			r.value = ordinate_copy[0];
			return r;
		end
		if (lo >= n) begin
			r.value = ordinate_copy[n-1];
			return r;
		end
		x0 = abscissa_copy[lo-1];
		x1 = abscissa_copy[lo];
		y0 = ordinate_copy[lo-1];
		y1 = ordinate_copy[lo];
		den = x1 - x0;
		r.at_edge = 1'b0;
		// A segment of zero or negative width returns its lower ordinate.
		if (den <= 0) begin
			r.value = y0;
			return r;
		end
		frac = (longint'(int'(qx) - x0) * 64'sd65536) / longint'(den);
		if (frac < 0)
			frac = 0;
		if (frac > 65536)
			frac = 65536;
		delta = (frac * longint'(y1 - y0)) / 64'sd65536;
		sum = longint'(y0) + delta;
		r.value = sum[COORD_W-1:0];
		return r;
	endfunction

	// Track configuration and writes, queue predictions, check results.
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		if (!arst_n) begin
			active_points = '0;
			for (int i = 0; i < CURVE_DEPTH; i++) begin
				abscissa_copy[i] = '0;
				ordinate_copy[i] = '0;
			end
			expected_lookups.delete();
			error_count <= 0;
			pending_lookups <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we)
				active_points = cfg_wdata;
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_lookups.size() == 0) begin
					error_count <= error_count + 1;
					$display("%0t: unexpected result transaction: value %0d, at_edge %0b",
						$time, value, at_edge);
				end else begin
					want = expected_lookups.pop_front();
					if (value !== want.value) begin
						error_count <= error_count + 1;
						$display("%0t: value mismatch: expected %0d, actual %0d",
							$time, want.value, value);
					end
					if (at_edge !== want.at_edge) begin
						error_count <= error_count + 1;
						$display("%0t: at_edge mismatch: expected %0b, actual %0b",
							$time, want.at_edge, at_edge);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (func == FUNC_WRITE) begin
					if (point_index < CURVE_DEPTH) begin
						abscissa_copy[point_index] = point_x;
						ordinate_copy[point_index] = point_y;
					end
				end else begin
					expected_lookups.push_back(interpolate(query_x));
				end
			end
			pending_lookups <= expected_lookups.size();
		end
	end

endmodule

/* verif/monotone_curve_linear_interp_core_tb.sv */
// ----------------------------------------------------------------------------
// monotone_curve_linear_interp_core_tb
// Drives point writes and curve lookups into the interpolation core under
// several idle and stall patterns, with a checker beside it that predicts
// and compares every result.
// ----------------------------------------------------------------------------
module monotone_curve_linear_interp_core_tb;
	import mcli_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CURVE_DEPTH       = 64;
	localparam int          SETTLE_CYCLES     = 48;
	localparam int          HOLD_CYCLES       = 300;
	localparam int          WATCHDOG_LIMIT    = 3000;
	localparam int          LOOKUPS_PER_PHASE = 34;
	localparam int          PHASES            = 12;
	localparam int          PRESSURE_PHASE    = 8;

	// Ways of laying out the abscissas of a curve.
	typedef enum logic [1:0] {
		SHAPE_SORTED,
		SHAPE_STEPPED,
		SHAPE_UNSORTED,
		SHAPE_FULL_SPAN
	} curve_shape_e;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [COUNT_W-1:0]        cfg_wdata;
	logic                      in_valid;
	logic                      in_ready;
	logic                      func;
	logic [INDEX_W-1:0]        point_index;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] query_x;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [COORD_W-1:0] value;
	logic                      at_edge;

	int  mismatches;
	int  pending_lookups;
	int  results_seen;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;
	int  idle_cycles;
	int  lookups_sent;
	int  writes_sent;

	// Abscissas as last written, used to aim lookups at the curve.
	logic signed [COORD_W-1:0] curve_x [CURVE_DEPTH];

	monotone_curve_linear_interp_core #(
		.MAX_POINTS(CURVE_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.point_index(point_index),
		.point_x    (point_x),
		.point_y    (point_y),
		.query_x    (query_x),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.at_edge    (at_edge)
	);

	monotone_curve_linear_interp_checker #(
		.CURVE_DEPTH(CURVE_DEPTH)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.point_index    (point_index),
		.point_x        (point_x),
		.point_y        (point_y),
		.query_x        (query_x),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.value          (value),
		.at_edge        (at_edge),
		.error_count    (mismatches),
		.pending_lookups(pending_lookups),
		.results_seen   (results_seen)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// End the run when no transaction of any kind moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Timeout: no transaction for %0d cycles", idle_cycles);
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	// Result side: random stalls, plus one long hold when asked for.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
		end
	end

	function automatic logic signed [COORD_W-1:0] rand_coord();
		return 16'($urandom);
	endfunction

	// Offer one transaction after an optional random gap and wait for it to go.
	task automatic send_item(input logic f, input logic [INDEX_W-1:0] idx,
		input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
		input logic signed [COORD_W-1:0] qx);
		while (int'($urandom_range(0, 99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		point_index <= idx;
		point_x <= px;
		point_y <= py;
		query_x <= qx;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_point(input int idx, input int x, input int y);
		curve_x[idx] = 16'(x);
		writes_sent++;
		send_item(FUNC_WRITE, 6'(idx), 16'(x), 16'(y), rand_coord());
	endtask

	task automatic lookup(input int qx);
		lookups_sent++;
		send_item(FUNC_QUERY, 6'($urandom), rand_coord(), rand_coord(), 16'(qx));
	endtask

	// Wait until every lookup has answered, then for the core to go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_lookups != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_points(input int n);
		cfg_we <= 1'b1;
		cfg_wdata <= 7'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Write entries 0 to m-1 with abscissas laid out as the shape says.
	task automatic load_curve(input int m, input curve_shape_e shape);
		int x;
		int step_max;
		step_max = (m > 0) ? 65535 / m : 0;
		if (shape == SHAPE_STEPPED)
			x = int'($urandom_range(0, 62000)) - 32768;
		else
			x = int'($urandom_range(0, step_max)) - 32768;
		for (int i = 0; i < m; i++) begin
			case (shape)
				SHAPE_SORTED: begin
					if (i > 0)
						x += int'($urandom_range(0, step_max));
				end
				SHAPE_STEPPED: begin
					// Repeated abscissas and very narrow segments.
					if (i > 0 && $urandom_range(0, 2) != 0)
						x += int'($urandom_range(1, 40));
				end
				SHAPE_UNSORTED: begin
					x = int'($urandom_range(0, 65535)) - 32768;
				end
				default: begin
					if (i == 0)
						x = -32768;
					else if (i == m - 1)
						x = 32767;
					else
						x += int'($urandom_range(0, step_max));
				end
			endcase
			write_point(i, x, rand_coord());
		end
	endtask

	// Choose a lookup abscissa, often inside segments of the current curve.
	function automatic int pick_query(input int m);
		int i;
		int a;
		int b;
		int sel;
		if (m == 0)
			return rand_coord();
		i = int'($urandom_range(0, m - 1));
		sel = int'($urandom_range(0, 9));
		if (sel <= 4 && i + 1 < m) begin
			a = curve_x[i];
			b = curve_x[i+1];
			if (a < b)
				return a + int'($urandom_range(0, b - a));
			return a;
		end
		if (sel == 5)
			return curve_x[i];
		if (sel == 8)
			return int'(curve_x[i]) + (($urandom_range(0, 1) == 0) ? 1 : -1);
		if (sel == 9)
			return ($urandom_range(0, 1) == 0) ? -32768 : 32767;
		return rand_coord();
	endfunction

	// Main stimulus: directed corners first, then randomized curve phases.
	initial begin
		int           phase_points [PHASES] = '{64, 3, 127, 2, 1, 64, 0, 17, 65, 40, 64, 8};
		curve_shape_e phase_shape [PHASES] = '{SHAPE_SORTED, SHAPE_STEPPED, SHAPE_UNSORTED,
			SHAPE_FULL_SPAN, SHAPE_SORTED, SHAPE_STEPPED, SHAPE_SORTED, SHAPE_FULL_SPAN,
			SHAPE_SORTED, SHAPE_UNSORTED, SHAPE_FULL_SPAN, SHAPE_STEPPED};
		int           send_pct [4] = '{0, 45, 0, 30};
		int           recv_pct [4] = '{0, 0, 45, 30};
		int           n;
		int           m;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		func = FUNC_WRITE;
		point_index = '0;
		point_x = '0;
		point_y = '0;
		query_x = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		idle_cycles = 0;
		lookups_sent = 0;
		writes_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty curve after reset.
		lookup(-32768);
		lookup(32767);

		// A small curve spanning the full range, with a repeated abscissa.
		write_point(0, -32768, 32767);
		write_point(1, -4096, -32768);
		write_point(2, 0, 32767);
		write_point(3, 0, 100);
		write_point(4, 32767, -32768);
		write_point(63, -1, -1);
		settle();
		set_points(5);
		lookup(-32768);
		lookup(-32767);
		lookup(-4096);
		lookup(-1);
		lookup(0);
		lookup(1);
		lookup(32766);
		lookup(32767);

		// Single point: every lookup clamps.
		settle();
		set_points(1);
		lookup(-32768);
		lookup(0);
		lookup(32767);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			n = phase_points[p];
			m = (n > CURVE_DEPTH) ? CURVE_DEPTH : n;
			send_idle_pct = send_pct[p % 4];
			recv_stall_pct = recv_pct[p % 4];
			load_curve(m, phase_shape[p]);
			settle();
			set_points(n);
			if (p == PRESSURE_PHASE)
				hold_req = 1'b1;
			for (int k = 0; k < LOOKUPS_PER_PHASE; k++) begin
				// Now and then rewrite a live entry between lookups.
				if (m > 0 && $urandom_range(0, 9) == 0)
					write_point(int'($urandom_range(0, m - 1)), rand_coord(), rand_coord());
				lookup(pick_query(m));
			end
			settle();
		end

		$display("Sent %0d lookups and %0d point writes over %0d curve settings.",
			lookups_sent, writes_sent, PHASES + 3);
		$display("Checked %0d results across empty, clamped, unsorted and over-capacity curves.",
			results_seen);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/mcli_pkg.sv
rtl/core/mcli_curve_mem.sv
rtl/core/mcli_frac_div.sv
rtl/core/mcli_blend.sv
rtl/core/monotone_curve_linear_interp_core.sv
verif/monotone_curve_linear_interp_checker.sv
verif/monotone_curve_linear_interp_core_tb.sv
